/* rtl/core/imuf_pkg.sv */
// ----------------------------------------------------------------------------
// imuf_pkg
// shared types and constants for the imu frame deframer
// ----------------------------------------------------------------------------
package imuf_pkg;

	localparam int POS_W  = 5;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	// frame positions
	localparam logic [POS_W-1:0] POS_HUNT     = 5'd0;
	localparam logic [POS_W-1:0] POS_HDR2     = 5'd1;
	localparam logic [POS_W-1:0] POS_CRC_LAST = 5'd16;
	localparam logic [POS_W-1:0] POS_CRC_HI   = 5'd17;
	localparam logic [POS_W-1:0] POS_CRC_LO   = 5'd18;

	// register indexes (address bit 2)
	localparam logic REG_HEADER_FIRST  = 1'b0;
	localparam logic REG_HEADER_SECOND = 1'b1;

	localparam logic [7:0] HEADER_FIRST_RST  = 8'hA5;
	localparam logic [7:0] HEADER_SECOND_RST = 8'h5A;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// control from frame tracker to crc unit
	typedef struct packed {
		logic clear;    // back to init value
		logic restart;  // init value folded with the byte
		logic update;   // fold the byte into the running value
	} crc_ctl_t;

endpackage

/* rtl/core/imuf_crc16.sv */
// ----------------------------------------------------------------------------
// imuf_crc16
// running reflected crc-16 register, one byte folded in per cycle
// ----------------------------------------------------------------------------
module imuf_crc16 (
	input  logic              clk,
	input  logic              arst_n,
	input  imuf_pkg::crc_ctl_t ctl,
	input  logic [7:0]        data,
	output logic [15:0]       crc
);
	import imuf_pkg::*;

	logic [15:0] crc_q;

	function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (r[0]) begin
				r = (r >> 1) ^ CRC_POLY;
			end else begin
				r = r >> 1;
			end
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
		end else if (ctl.clear) begin
			crc_q <= CRC_INIT;
		end else if (ctl.restart) begin
			crc_q <= crc_byte(CRC_INIT, data);
		end else if (ctl.update) begin
			crc_q <= crc_byte(crc_q, data);
		end
	end

	assign crc = crc_q;

endmodule

/* rtl/core/imu_frame_deframer_crc16.sv */
// ----------------------------------------------------------------------------
// imu_frame_deframer_crc16
// serial byte deframer for 19-byte imu frames with crc-16 check
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_ready, rx_byte) takes one received byte per
//   word. the block hunts for the two header bytes, then walks a 19-byte
//   frame: crc-16 (reflected, poly 0xA001, init 0xFFFF) over bytes 0..16,
//   little-endian pitch/yaw/roll words at bytes 3-6, 8-11, 13-16, crc at
//   bytes 17 (high) and 18 (low).
//   output channel (out_valid/out_ready) carries one word per frame: the
//   held pitch/yaw/roll words plus crc_ok. held words change only on a match.
//   throughput: one byte per cycle while in_ready is high, via byte crc update.
//   result: shows on out_valid in the cycle after frame byte 18 is
//   accepted, from an output register.
//   stall: while a result waits unread, bytes keep flowing in; only the final
//   byte of the next frame is held off until the output register frees up.
//   reset: headers return to 0xA5 / 0x5A, hunting, held words zero, no
//   result pending. no clearing pass is needed.
//   config: apb registers header_first at 0x0, header_second at 0x4; write
//   only while idle.
// ----------------------------------------------------------------------------
module imu_frame_deframer_crc16 (
	input  logic                        clk,
	input  logic                        arst_n,
	// apb config port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [imuf_pkg::ADDR_W-1:0] paddr,
	input  logic [imuf_pkg::DATA_W-1:0] pwdata,
	output logic [imuf_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	// byte input
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [7:0]                  rx_byte,
	// frame result
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [31:0]                 pitch_bits,
	output logic [31:0]                 yaw_bits,
	output logic [31:0]                 roll_bits,
	output logic                        crc_ok
);
	import imuf_pkg::*;

	// config registers
	logic [7:0] header_first_q;
	logic [7:0] header_second_q;

	// frame tracking state
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] pos_d;
	logic [7:0]       crc_hi_q;
	logic [31:0]      pitch_cap_q;
	logic [31:0]      yaw_cap_q;
	logic [31:0]      roll_cap_q;
	logic [31:0]      pitch_held_q;
	logic [31:0]      yaw_held_q;
	logic [31:0]      roll_held_q;

	// output register
	logic        out_valid_q;
	logic [31:0] pitch_out_q;
	logic [31:0] yaw_out_q;
	logic [31:0] roll_out_q;
	logic        crc_ok_q;

	crc_ctl_t    crc_ctl;
	logic [15:0] crc_val;
	logic        accept;
	logic        last_byte;
	logic        match;
	logic        hunting;

	// apb: writes complete in the access phase, no wait states
	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_first_q  <= HEADER_FIRST_RST;
			header_second_q <= HEADER_SECOND_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_HEADER_SECOND) begin
				header_second_q <= pwdata[7:0];
			end else begin
				header_first_q <= pwdata[7:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == REG_HEADER_FIRST) begin
			prdata = {{(DATA_W-8){1'b0}}, header_first_q};
		end else begin
			prdata = {{(DATA_W-8){1'b0}}, header_second_q};
		end
	end

	// only the frame's last byte needs room in the output register
	assign last_byte = (pos_q == POS_CRC_LO);
	assign in_ready  = !last_byte || !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign hunting   = (pos_q == POS_HUNT) || (pos_q > POS_CRC_LO);
	assign match     = ({crc_hi_q, rx_byte} == crc_val);

	// next position and crc control
	always_comb begin
		pos_d   = pos_q;
		crc_ctl = '0;
		if (accept) begin
			if (hunting || (pos_q == POS_HDR2 && rx_byte != header_second_q)) begin
				// start a frame on the first header byte, else keep hunting
				if (rx_byte == header_first_q) begin
					crc_ctl.restart = 1'b1;
					pos_d           = POS_HDR2;
				end else begin
					crc_ctl.clear = 1'b1;
					pos_d         = POS_HUNT;
				end
			end else if (pos_q <= POS_CRC_LAST) begin
				crc_ctl.update = 1'b1;
				pos_d          = pos_q + 5'd1;
			end else if (pos_q == POS_CRC_HI) begin
				pos_d = POS_CRC_LO;
			end else begin
				crc_ctl.clear = 1'b1;
				pos_d         = POS_HUNT;
			end
		end
	end

	imuf_crc16 u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (crc_ctl),
		.data   (rx_byte),
		.crc    (crc_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_HUNT;
		end else begin
			pos_q <= pos_d;
		end
	end

	// capture shift registers, crc high byte and held words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_hi_q     <= 8'h00;
			pitch_cap_q  <= '0;
			yaw_cap_q    <= '0;
			roll_cap_q   <= '0;
			pitch_held_q <= '0;
			yaw_held_q   <= '0;
			roll_held_q  <= '0;
		end else if (accept) begin
			if (pos_q inside {[5'd3:5'd6]}) begin
				pitch_cap_q <= {rx_byte, pitch_cap_q[31:8]};
			end
			if (pos_q inside {[5'd8:5'd11]}) begin
				yaw_cap_q <= {rx_byte, yaw_cap_q[31:8]};
			end
			if (pos_q inside {[5'd13:5'd16]}) begin
				roll_cap_q <= {rx_byte, roll_cap_q[31:8]};
			end
			if (pos_q == POS_CRC_HI) begin
				crc_hi_q <= rx_byte;
			end
			if (last_byte && match) begin
				pitch_held_q <= pitch_cap_q;
				yaw_held_q   <= yaw_cap_q;
				roll_held_q  <= roll_cap_q;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && last_byte) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last_byte) begin
			// on a match the fresh captures go out, else the old held words
			pitch_out_q <= match ? pitch_cap_q : pitch_held_q;
			yaw_out_q   <= match ? yaw_cap_q   : yaw_held_q;
			roll_out_q  <= match ? roll_cap_q  : roll_held_q;
			crc_ok_q    <= match;
		end
	end

	assign out_valid  = out_valid_q;
	assign pitch_bits = pitch_out_q;
	assign yaw_bits   = yaw_out_q;
	assign roll_bits  = roll_out_q;
	assign crc_ok     = crc_ok_q;

	// a result only appears after the frame's last byte was taken
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(accept && last_byte))
		else $error("result without final frame byte");

	// crc low byte always follows the crc high byte
	a_crc_hi_to_lo: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && pos_q == POS_CRC_HI) |=> (pos_q == POS_CRC_LO))
		else $error("frame position skipped crc low byte");

	// position never leaves the frame range
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_CRC_LO)
		else $error("frame position out of range");

	// a good-crc result carries the words now held
	a_ok_matches_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && crc_ok_q) |-> (pitch_out_q == pitch_held_q &&
			yaw_out_q == yaw_held_q && roll_out_q == roll_held_q))
		else $error("crc ok result differs from held words");

endmodule
